/* design/pf_pkg.sv */
// pf_pkg: shared constants, command and status types for the prime factorizer
// used by pf_datapath, pf_ctrl and prime_factorizer_top
`default_nettype none

package pf_pkg;

  // fixed field widths of the input and result transactions
  localparam int VALUE_W  = 16;
  localparam int FACTOR_W = 16;
  localparam int MULT_W   = 5;
  localparam int INDEX_W  = 3;

  // default for the top level VALUE_WIDTH parameter
  localparam int VALUE_WIDTH_DEF = 16;

  // most distinct primes reported for one value
  localparam int RESULT_CAP = 6;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,  // value of zero or one, no factors
    EMIT_DIV  = 2'd1,  // trial divisor with its multiplicity
    EMIT_REM  = 2'd2   // prime remainder left after the square test
  } emit_kind_e;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       take_quot;
    logic       next_d;
    logic       emit;
    emit_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic in_trivial;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic mult_nz;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/prime_factorizer_top.sv */
// each value is worked by trial division; W = min(VALUE_WIDTH, 16) bits take part
// and each trial is a serial divide over W bits
// trials run up to the square root of the remainder plus one per repeated
// factor, worst case near 256 for a 16-bit prime
// one value in flight; next value taken once the last result is in the output register
// reset clears the sequencer and the output valid, no clearing pass
`default_nettype none

module prime_factorizer_top #(
  parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pf_pkg::VALUE_W-1:0]     value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pf_pkg::FACTOR_W-1:0]         prime_factor_o,
  output logic [pf_pkg::MULT_W-1:0]           multiplicity_o,
  output logic [pf_pkg::INDEX_W-1:0]          factor_index_o,
  output logic                                is_last_o,
  output logic                                none_found_o
);

  pf_pkg::cmd_t    cmd;
  pf_pkg::status_t status;

  pf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pf_datapath #(
    .ValueWidth(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prime_factor_o(prime_factor_o),
    .multiplicity_o(multiplicity_o),
    .factor_index_o(factor_index_o),
    .is_last_o     (is_last_o),
    .none_found_o  (none_found_o)
  );

endmodule

`default_nettype wire

/* design/pf_div.sv */
// pf_div: iterative restoring divider, one quotient bit per cycle
// standalone unit, no package dependencies
`default_nettype none

module pf_div #(
  parameter int Width = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [Width-1:0]      quotient_o,
  output logic [Width-1:0]      remainder_o
);

  localparam int CntW = (Width > 1) ? $clog2(Width) : 1;

  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[Width-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[Width-1:0] : shifted[Width-1:0];
      quo_d = {quo_q[Width-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* design/pf_datapath.sv */
// pf_datapath: remaining value, trial divisor and its square, multiplicity,
// result count and the output register; depends on pf_pkg and pf_div
`default_nettype none

module pf_datapath #(
  parameter int ValueWidth = pf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pf_pkg::VALUE_W-1:0]    value_i,
  input  wire pf_pkg::cmd_t                  cmd_i,
  output pf_pkg::status_t                    status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pf_pkg::FACTOR_W-1:0]        prime_factor_o,
  output logic [pf_pkg::MULT_W-1:0]          multiplicity_o,
  output logic [pf_pkg::INDEX_W-1:0]         factor_index_o,
  output logic                               is_last_o,
  output logic                               none_found_o
);

  // bits of the input that take part; the field itself is 16 bits
  localparam int NW      = (ValueWidth < pf_pkg::VALUE_W) ? ValueWidth : pf_pkg::VALUE_W;
  localparam int DsqW    = 2 * NW;
  localparam int MultW   = $clog2(NW + 1);
  localparam int FactorW = pf_pkg::FACTOR_W;
  localparam int MultOW  = pf_pkg::MULT_W;
  localparam int IndexW  = pf_pkg::INDEX_W;

  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     d_q, d_d;
  logic [DsqW-1:0]   dsq_q, dsq_d;
  logic [MultW-1:0]  mult_q, mult_d;
  logic [IndexW-1:0] cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [FactorW-1:0] fac_q, fac_d;
  logic [MultOW-1:0]  omult_q, omult_d;
  logic [IndexW-1:0]  oidx_q, oidx_d;
  logic               last_q, last_d;
  logic               none_q, none_d;

  logic              div_busy;
  logic              div_done;
  logic [NW-1:0]     quotient;
  logic [NW-1:0]     remainder;
  logic              emit_last;
  logic              out_free;

  pf_div #(
    .Width(NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  // non-divisor results are last; a divisor one once n is 1 or list full
  assign emit_last = (cmd_i.kind != pf_pkg::EMIT_DIV) || (n_q == NW'(1)) ||
                     (cnt_q == IndexW'(pf_pkg::RESULT_CAP - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.in_trivial = (value_i[NW-1:0] <= NW'(1));
    status_o.sq_gt      = (dsq_q > DsqW'(n_q));
    status_o.div_done   = div_done;
    status_o.rem_zero   = (remainder == '0);
    status_o.mult_nz    = (mult_q != '0);
    status_o.emit_last  = emit_last;
    status_o.out_free   = out_free;
  end

  always_comb begin
    n_d   = n_q;
    d_d   = d_q;
    dsq_d = dsq_q;
    mult_d = mult_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      n_d    = value_i[NW-1:0];
      d_d    = NW'(2);
      dsq_d  = DsqW'(4);
      mult_d = '0;
      cnt_d  = '0;
    end
    if (cmd_i.take_quot) begin
      n_d    = quotient;
      mult_d = mult_q + MultW'(1);
    end
    if (cmd_i.next_d) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_d    = d_q + NW'(1);
      dsq_d  = dsq_q + DsqW'({d_q, 1'b0}) + DsqW'(1);
      mult_d = '0;
    end
    if (cmd_i.emit) begin
      cnt_d = cnt_q + IndexW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    fac_d       = fac_q;
    omult_d     = omult_q;
    oidx_d      = oidx_q;
    last_d      = last_q;
    none_d      = none_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      oidx_d      = cnt_q;
      last_d      = emit_last;
      unique case (cmd_i.kind)
        pf_pkg::EMIT_DIV: begin
          fac_d   = FactorW'(d_q);
          omult_d = MultOW'(mult_q);
          none_d  = 1'b0;
        end
        pf_pkg::EMIT_REM: begin
          fac_d   = FactorW'(n_q);
          omult_d = MultOW'(1);
          none_d  = 1'b0;
        end
        default: begin
          fac_d   = '0;
          omult_d = '0;
          none_d  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    dsq_q   <= dsq_d;
    mult_q  <= mult_d;
    cnt_q   <= cnt_d;
    fac_q   <= fac_d;
    omult_q <= omult_d;
    oidx_q  <= oidx_d;
    last_q  <= last_d;
    none_q  <= none_d;
  end

  assign out_valid_o    = out_valid_q;
  assign prime_factor_o = fac_q;
  assign multiplicity_o = omult_q;
  assign factor_index_o = oidx_q;
  assign is_last_o      = last_q;
  assign none_found_o   = none_q;

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result written while output register is occupied");

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("division started while divider busy");

  a_div_emit_mult : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.kind == pf_pkg::EMIT_DIV) |-> (mult_q != '0))
    else $error("divisor result with zero multiplicity");

  a_load_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (d_q == NW'(2)) && (dsq_q == DsqW'(4)))
    else $error("trial divisor not set up on load");

endmodule

`default_nettype wire

/* design/pf_ctrl.sv */
// pf_ctrl: sequencer for the trial division loop
// drives pf_pkg::cmd_t to the datapath and reads pf_pkg::status_t back
`default_nettype none

module pf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pf_pkg::status_t status_i,
  output pf_pkg::cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  pf_pkg::emit_kind_e kind_q, kind_d;

  always_comb begin
    state_d         = state_q;
    kind_d          = kind_q;
    in_stall_o      = 1'b1;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.take_quot = 1'b0;
    cmd_o.next_d    = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.kind      = kind_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_trivial) begin
            kind_d  = pf_pkg::EMIT_NONE;
            state_d = S_EMIT;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // divisor squared beyond the remainder: remainder is prime
        if (status_i.sq_gt) begin
          kind_d  = pf_pkg::EMIT_REM;
          state_d = S_EMIT;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.take_quot = 1'b1;
            state_d         = S_START;
          end else if (status_i.mult_nz) begin
            kind_d  = pf_pkg::EMIT_DIV;
            state_d = S_EMIT;
          end else begin
            cmd_o.next_d = 1'b1;
            state_d      = S_CHECK;
          end
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_d = 1'b1;
            state_d      = S_CHECK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= pf_pkg::EMIT_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench for prime_factorizer_top: directed table then random values, results
// checked field by field against the table or by trial division; needs pf_pkg and the rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH     = pf_pkg::VALUE_WIDTH_DEF;
  localparam int RANDOM_ITEMS    = 100;
  localparam int WATCHDOG_LIMIT  = 60000;
  localparam int TAIL_CYCLES     = 100;
  localparam int N_DIRECTED      = 19;

  typedef struct packed {
    logic [pf_pkg::FACTOR_W-1:0] prime_factor;
    logic [pf_pkg::MULT_W-1:0]   multiplicity;
    logic [pf_pkg::INDEX_W-1:0]  factor_index;
    logic                        is_last;
    logic                        none_found;
  } factor_rec_t;

  // typed rows are single-result values whose answer is obvious
  typedef struct packed {
    logic [pf_pkg::VALUE_W-1:0]  value;
    logic                        typed;
    logic [pf_pkg::FACTOR_W-1:0] prime_factor;
    logic [pf_pkg::MULT_W-1:0]   multiplicity;
  } directed_row_t;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'd0,     1'b1, 16'd0,     5'd0},
    '{16'd1,     1'b1, 16'd0,     5'd0},
    '{16'd2,     1'b1, 16'd2,     5'd1},
    '{16'd3,     1'b1, 16'd3,     5'd1},
    '{16'd4,     1'b1, 16'd2,     5'd2},
    '{16'd49,    1'b1, 16'd7,     5'd2},
    '{16'd32768, 1'b1, 16'd2,     5'd15},
    '{16'd65521, 1'b1, 16'd65521, 5'd1},
    '{16'd65535, 1'b0, 16'd0,     5'd0},
    '{16'd65534, 1'b0, 16'd0,     5'd0},
    '{16'd30030, 1'b0, 16'd0,     5'd0},
    '{16'd60060, 1'b0, 16'd0,     5'd0},
    '{16'd65025, 1'b0, 16'd0,     5'd0},
    '{16'd6,     1'b0, 16'd0,     5'd0},
    '{16'd12,    1'b0, 16'd0,     5'd0},
    '{16'd15,    1'b0, 16'd0,     5'd0},
    '{16'd32767, 1'b0, 16'd0,     5'd0},
    '{16'd40000, 1'b0, 16'd0,     5'd0},
    '{16'd1,     1'b1, 16'd0,     5'd0}
  };

  int unsigned small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [pf_pkg::VALUE_W-1:0]  value_i     = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [pf_pkg::FACTOR_W-1:0] prime_factor_o;
  logic [pf_pkg::MULT_W-1:0]   multiplicity_o;
  logic [pf_pkg::INDEX_W-1:0]  factor_index_o;
  logic                        is_last_o;
  logic                        none_found_o;

  factor_rec_t expected_factors [$];
  int          fail_count  = 0;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          stall_cycle = 0;

  prime_factorizer_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prime_factor_o (prime_factor_o),
    .multiplicity_o (multiplicity_o),
    .factor_index_o (factor_index_o),
    .is_last_o      (is_last_o),
    .none_found_o   (none_found_o)
  );

  always #1 clk_i = ~clk_i;

  // trial division, stopping once the divisor squared passes the remainder or the list is full
  function automatic void predict_factors(input logic [pf_pkg::VALUE_W-1:0] value);
    longint unsigned rem;
    longint unsigned divisor;
    int unsigned     count;
    int unsigned     mult;
    factor_rec_t     rec;
    rem = longint'(value) & ((64'd1 << VALUE_WIDTH) - 1);
    if (rem <= 1) begin
      rec = '{prime_factor: '0, multiplicity: '0, factor_index: '0,
              is_last: 1'b1, none_found: 1'b1};
      expected_factors.push_back(rec);
      return;
    end
    divisor = 2;
    count   = 0;
    while (rem > 1 && count < pf_pkg::RESULT_CAP) begin
      if (divisor * divisor > rem) begin
        rec = '{prime_factor: pf_pkg::FACTOR_W'(rem), multiplicity: pf_pkg::MULT_W'(1),
                factor_index: pf_pkg::INDEX_W'(count), is_last: 1'b0,
                none_found: 1'b0};
        expected_factors.push_back(rec);
        count++;
        rem = 1;
      end else begin
        if (rem % divisor == 0) begin
          mult = 0;
          while (rem % divisor == 0) begin
            rem = rem / divisor;
            mult++;
          end
          rec = '{prime_factor: pf_pkg::FACTOR_W'(divisor),
                  multiplicity: pf_pkg::MULT_W'(mult),
                  factor_index: pf_pkg::INDEX_W'(count), is_last: 1'b0,
                  none_found: 1'b0};
          expected_factors.push_back(rec);
          count++;
        end
        divisor++;
      end
    end
    expected_factors[expected_factors.size() - 1].is_last = 1'b1;
  endfunction

  function automatic logic [pf_pkg::VALUE_W-1:0] random_value();
    longint unsigned v;
    int unsigned     p;
    case ($urandom_range(0, 9)) inside
      [0:3]: v = $urandom_range(0, 65535);
      [4:5]: v = $urandom_range(0, 64);
      [6:8]: begin
        // smooth numbers give the longest result lists
        v = 1;
        repeat ($urandom_range(1, 14)) begin
          p = small_primes[$urandom_range(0, 9)];
          if (v * p <= 65535) v = v * p;
        end
      end
      default: begin
        p = small_primes[$urandom_range(0, 9)];
        v = p;
        while (v * p <= 65535 && $urandom_range(0, 5) != 0) v = v * p;
      end
    endcase
    return pf_pkg::VALUE_W'(v);
  endfunction

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // holds the transaction until the stall drops; returns at the accepting edge
  task automatic send_value(input logic [pf_pkg::VALUE_W-1:0] value);
    pace_sender();
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic check_result(input factor_rec_t exp_rec);
    if (prime_factor_o !== exp_rec.prime_factor) begin
      $error("prime_factor: expected %0d, got %0d", exp_rec.prime_factor, prime_factor_o);
      fail_count++;
    end
    if (multiplicity_o !== exp_rec.multiplicity) begin
      $error("multiplicity: expected %0d, got %0d", exp_rec.multiplicity, multiplicity_o);
      fail_count++;
    end
    if (factor_index_o !== exp_rec.factor_index) begin
      $error("factor_index: expected %0d, got %0d", exp_rec.factor_index, factor_index_o);
      fail_count++;
    end
    if (is_last_o !== exp_rec.is_last) begin
      $error("is_last: expected %0d, got %0d", exp_rec.is_last, is_last_o);
      fail_count++;
    end
    if (none_found_o !== exp_rec.none_found) begin
      $error("none_found: expected %0d, got %0d", exp_rec.none_found, none_found_o);
      fail_count++;
    end
  endtask

  // result side: check accepted transactions, stall on a pattern of its own
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_factors.size() == 0) begin
        $error("prime_factor: expected none, got %0d", prime_factor_o);
        fail_count++;
      end else begin
        check_result(expected_factors.pop_front());
      end
    end
    stall_cycle++;
    if (stall_cycle % 128 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ((stall_cycle % 32) < 20);
    endcase
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    factor_rec_t                rec;
    logic [pf_pkg::VALUE_W-1:0] value;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value);
      if (directed_rows[i].typed) begin
        rec = '{prime_factor: directed_rows[i].prime_factor,
                multiplicity: directed_rows[i].multiplicity,
                factor_index: '0, is_last: 1'b1,
                none_found: (directed_rows[i].value <= 1)};
        expected_factors.push_back(rec);
      end else begin
        predict_factors(directed_rows[i].value);
      end
    end

    repeat (RANDOM_ITEMS) begin
      value = random_value();
      send_value(value);
      predict_factors(value);
    end
    in_valid_i <= 1'b0;

    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
